// ----- sv/swm_pkg.sv -----
package swm_pkg;

    // Window length and sample format
    localparam int WINDOW   = 21;
    localparam int SAMPLE_W = 16;

    // Age counter wide enough to name every slot of the window
    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Middle slots of the sorted chain; equal for an odd window
    localparam int MID_LO = (WINDOW - 1) / 2;
    localparam int MID_HI = WINDOW / 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [AGE_W-1:0]           age_t;

    localparam age_t AGE_OLDEST = age_t'(WINDOW - 1);

    // What one cell shows its neighbors
    typedef struct packed {
        sample_t value;
        age_t    age;
        logic    move_left;
        logic    move_right;
    } cell_port_t;

    // Tie-off at both ends of the chain: nothing moves in from outside
    localparam cell_port_t CELL_EDGE = '0;

endpackage

// ----- sv/swm_cell.sv -----
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  sample_t    sample,
    input  age_t       init_age,
    input  logic       old_before,
    output logic       old_through,
    input  cell_port_t left,
    input  cell_port_t right,
    output cell_port_t own
);

    sample_t value_reg;
    sample_t value_next;
    age_t    age_reg;
    age_t    age_next;
    logic    old;
    logic    gt;

    // Classify this entry against the oldest one and the new sample
    assign old = (age_reg == AGE_OLDEST);
    assign gt  = (value_reg > sample);

    assign old_through    = old_before | old;
    assign own.value      = value_reg;
    assign own.age        = age_reg;
    assign own.move_left  = old_before & ~gt & ~old;
    assign own.move_right = gt & ~old_before & ~old;

    // Pick the entry that lands here: right neighbor, self, left neighbor or sample
    always_comb
    begin
        if (right.move_left)
        begin
            value_next = right.value;
            age_next   = right.age + age_t'(1);
        end
        else if (!old && (old_before == gt))
        begin
            value_next = value_reg;
            age_next   = age_reg + age_t'(1);
        end
        else if (left.move_right)
        begin
            value_next = left.value;
            age_next   = left.age + age_t'(1);
        end
        else
        begin
            value_next = sample;
            age_next   = '0;
        end
    end

    // Advance on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= init_age;
        end
        else if (load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// ----- sv/sliding_window_median_filter.sv -----
// Running median over the last WINDOW signed 16-bit samples.
//
// Input channel: sample_in with sample_valid / sample_stall. A sample is
// taken on a clock edge with sample_valid high and sample_stall low.
// Output channel: median_out with median_valid / median_stall, one result
// per input transfer, in order.
//
// The window is kept sorted in a chain of WINDOW cells, each holding one
// sample and its age. On each transfer the oldest sample leaves its cell
// and the new one is inserted, every cell moving at most one place.
// The accepted sample is written into the cell chain, and the median of the
// updated chain is then loaded into the output register on median_out.
// Throughput: one sample per cycle while the output is not full and stalled.
//
// Reset clears the window to zeros, so the first WINDOW-1 medians include
// those zeros. When the receiver stalls, the result is held in the output
// register, one more sample can wait in the stage ahead of it, and then
// sample_stall rises until the output is taken.
module sliding_window_median_filter
    import swm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample_in,
    output logic    median_valid,
    input  logic    median_stall,
    output sample_t median_out
);

    cell_port_t            ports [WINDOW];
    logic [WINDOW:0]       old_chain;
    logic                  accept;
    logic                  adv;
    logic                  upd_reg;
    logic                  upd_next;
    logic                  median_valid_reg;
    logic                  median_valid_next;
    sample_t               median_reg;
    logic signed [SAMPLE_W:0] mid_sum;

    assign old_chain[0] = 1'b0;

    // Sorted chain of cells
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        cell_port_t left_port;
        cell_port_t right_port;

        if (i == 0)
        begin : g_first
            assign left_port = CELL_EDGE;
        end
        else
        begin : g_left
            assign left_port = ports[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_last
            assign right_port = CELL_EDGE;
        end
        else
        begin : g_right
            assign right_port = ports[i+1];
        end

        swm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (accept),
            .sample      (sample_in),
            .init_age    (age_t'(i)),
            .old_before  (old_chain[i]),
            .old_through (old_chain[i+1]),
            .left        (left_port),
            .right       (right_port),
            .own         (ports[i])
        );
    end

    // Handshake: the update stage holds while the output register is full and stalled
    assign adv          = ~median_valid_reg | ~median_stall;
    assign sample_stall = upd_reg & ~adv;
    assign accept       = sample_valid & ~sample_stall;
    assign upd_next     = accept | (upd_reg & ~adv);

    assign median_valid_next = adv ? upd_reg : median_valid_reg;

    // Median of the two middle cells, floor of their mean
    assign mid_sum = {ports[MID_LO].value[SAMPLE_W-1], ports[MID_LO].value}
                   + {ports[MID_HI].value[SAMPLE_W-1], ports[MID_HI].value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg          <= 1'b0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            upd_reg          <= upd_next;
            median_valid_reg <= median_valid_next;
        end
    end

    // Load the result when the update stage moves forward
    always_ff @(posedge clk)
    begin
        if (adv && upd_reg)
        begin
            median_reg <= mid_sum[SAMPLE_W:1];
        end
    end

    assign median_valid = median_valid_reg;
    assign median_out   = median_reg;

`ifndef SYNTHESIS
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        old_chain[WINDOW])
        else $error("no cell holds the oldest sample");

    a_accept_marks_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> upd_reg)
        else $error("accepted sample lost before the output stage");

    a_blocked_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_reg && !adv) |=> (upd_reg && median_valid))
        else $error("pending update dropped while output stalled");

    a_update_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_reg && adv) |=> median_valid)
        else $error("advancing update did not produce a result");
`endif

endmodule
